>>> rtl/core/lpsc_pkg.sv
// Shared types and constants for the length-prefixed to start-code converter.
package lpsc_pkg;

    // Parse phase of the front end.
    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_PAY   = 2'd1,
        PH_TRAIL = 2'd2
    } phase_t;

    // Work handed from the front end to the back end.
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_SIZE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEYS_ONLY   = 1'b1;
    localparam logic [2:0] LEN_SIZE_RESET = 3'd4;

    // Start code 00 00 00 01.
    localparam logic [7:0] SC_ZERO_BYTE = 8'h00;
    localparam logic [7:0] SC_LAST_BYTE = 8'h01;
    localparam logic [1:0] SC_LAST_IDX  = 2'd3;

endpackage

>>> rtl/core/lpsc_front.sv
// Front end: configuration registers, length prefix parsing and command generation.
module lpsc_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [lpsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lpsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               accept,
    input  logic [7:0]                         data_byte,
    input  logic [24:0]                        bytes_remaining,
    input  logic                               is_keyframe,
    output logic                               cmd_valid,
    output lpsc_pkg::cmd_t                     cmd
);
    import lpsc_pkg::*;

    logic [2:0]  length_size_reg;
    logic        keys_only_reg;
    phase_t      phase_reg, phase_next;
    logic [1:0]  prefix_seen_reg, prefix_seen_next;
    logic [31:0] unit_length_reg, unit_length_next;
    logic [31:0] payload_left_reg, payload_left_next;

    logic        last_byte;
    logic        room;
    logic        drop;
    logic [2:0]  lsz;
    logic        wide;
    logic        final_prefix;
    logic [31:0] unit_length_upd;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_size_reg <= LEN_SIZE_RESET;
            keys_only_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LENGTH_SIZE: length_size_reg <= cfg_data;
                REG_KEYS_ONLY:   keys_only_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Effective prefix size: out-of-range settings act as one byte.
    always_comb
    begin
        case (length_size_reg)
            3'd2:    lsz = 3'd2;
            3'd3:    lsz = 3'd3;
            3'd4:    lsz = 3'd4;
            default: lsz = 3'd1;
        endcase
    end

    // Classification of the incoming byte.
    assign wide         = (lsz == 3'd2) || (lsz == 3'd4);
    assign last_byte    = (bytes_remaining <= 25'd1);
    assign room         = (bytes_remaining > 25'd4);
    assign drop         = keys_only_reg && !is_keyframe;
    assign final_prefix = (({1'b0, prefix_seen_reg} + 3'd1) >= lsz);

    // Length assembly: big-endian for two and four byte prefixes, first byte otherwise.
    always_comb
    begin
        if (wide)
            unit_length_upd = {unit_length_reg[23:0], data_byte};
        else if (prefix_seen_reg == 2'd0)
            unit_length_upd = {24'd0, data_byte};
        else
            unit_length_upd = unit_length_reg;
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (!drop)
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        if ((prefix_seen_reg == 2'd0) && !room)
                            phase_next = PH_TRAIL;
                        else if (final_prefix)
                            phase_next = (unit_length_upd != 32'd0) ? PH_PAY : PH_LEN;
                    end
                    PH_PAY:
                    begin
                        if (payload_left_reg == 32'd1)
                            phase_next = PH_LEN;
                    end
                    default: phase_next = phase_reg;
                endcase
            end
            if (last_byte)
                phase_next = PH_LEN;
        end
    end

    // Counters, length registers and the command toward the queue.
    always_comb
    begin
        prefix_seen_next  = prefix_seen_reg;
        unit_length_next  = unit_length_reg;
        payload_left_next = payload_left_reg;
        cmd_valid         = 1'b0;
        cmd.kind          = CMD_DATA;
        cmd.data          = data_byte;
        if (accept)
        begin
            if (!drop)
            begin
                case (phase_reg)
                    PH_LEN:
                    begin
                        if (!((prefix_seen_reg == 2'd0) && !room))
                        begin
                            if (final_prefix)
                            begin
                                cmd_valid         = 1'b1;
                                cmd.kind          = CMD_START;
                                payload_left_next = unit_length_upd;
                                unit_length_next  = 32'd0;
                                prefix_seen_next  = 2'd0;
                            end
                            else
                            begin
                                unit_length_next = unit_length_upd;
                                prefix_seen_next = prefix_seen_reg + 2'd1;
                            end
                        end
                    end
                    PH_PAY:
                    begin
                        cmd_valid         = 1'b1;
                        payload_left_next = payload_left_reg - 32'd1;
                    end
                    default: ;
                endcase
            end
            // Sample end returns everything to length reading.
            if (last_byte)
            begin
                prefix_seen_next  = 2'd0;
                unit_length_next  = 32'd0;
                payload_left_next = 32'd0;
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_LEN;
            prefix_seen_reg  <= 2'd0;
            unit_length_reg  <= 32'd0;
            payload_left_reg <= 32'd0;
        end
        else
        begin
            phase_reg        <= phase_next;
            prefix_seen_reg  <= prefix_seen_next;
            unit_length_reg  <= unit_length_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

>>> rtl/core/lpsc_cmd_fifo.sv
// Short command queue between the front end and the back end.
module lpsc_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lpsc_pkg::cmd_t wr_cmd,
    input  logic           rd_en,
    output lpsc_pkg::cmd_t rd_cmd,
    output logic           not_empty,
    output logic           full
);
    import lpsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_cmd    = mem[rd_ptr_reg];

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_cmd;
    end

endmodule

>>> rtl/core/lpsc_back.sv
// Back end: expands commands into output bytes held in an output register.
module lpsc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  lpsc_pkg::cmd_t head,
    output logic           head_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           is_start_code,
    output logic           run_last
);
    import lpsc_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] sc_idx_reg, sc_idx_next;
    logic [7:0] byte_reg, byte_next;
    logic       sc_reg, sc_next;
    logic       last_reg, last_next;
    logic       load;

    // The output register refills whenever it is free or being transferred.
    assign load = head_valid && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg && !pop;
        sc_idx_next    = sc_idx_reg;
        byte_next      = byte_reg;
        sc_next        = sc_reg;
        last_next      = last_reg;
        head_pop       = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            case (head.kind)
                CMD_START:
                begin
                    sc_next = 1'b1;
                    if (sc_idx_reg == SC_LAST_IDX)
                    begin
                        byte_next   = SC_LAST_BYTE;
                        last_next   = 1'b1;
                        sc_idx_next = 2'd0;
                        head_pop    = 1'b1;
                    end
                    else
                    begin
                        byte_next   = SC_ZERO_BYTE;
                        last_next   = 1'b0;
                        sc_idx_next = sc_idx_reg + 2'd1;
                    end
                end
                CMD_DATA:
                begin
                    byte_next = head.data;
                    sc_next   = 1'b0;
                    last_next = 1'b1;
                    head_pop  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sc_idx_reg    <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sc_idx_reg    <= sc_idx_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        sc_reg   <= sc_next;
        last_reg <= last_next;
    end

    assign empty         = !out_valid_reg;
    assign out_byte      = byte_reg;
    assign is_start_code = sc_reg;
    assign run_last      = last_reg;

endmodule

>>> rtl/core/length_prefixed_to_start_code.sv
// Top level of the length-prefixed (AVCC) to start-code (Annex B) converter.
// Path: a transferred byte passes through the command queue and then the output register.
// Throughput: one input byte and, while pop is high, one output byte per cycle; a start code is four
// output bytes, so input stalls only when the command queue fills behind the output.
// Reset: rst_n clears the parse state, queue and output register; length_size is 4,
// keys_only is 0, and no clearing pass is needed.
module length_prefixed_to_start_code #(
    parameter int CMD_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lpsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lpsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic [24:0]                       bytes_remaining,
    input  logic                              is_keyframe,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        out_byte,
    output logic                              is_start_code,
    output logic                              run_last
);
    import lpsc_pkg::*;

    logic accept;
    logic cmd_valid;
    cmd_t cmd;
    cmd_t head;
    logic head_valid;
    logic head_pop;

    assign accept = push && !full;

    // Parse and classify incoming bytes.
    lpsc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .accept          (accept),
        .data_byte       (data_byte),
        .bytes_remaining (bytes_remaining),
        .is_keyframe     (is_keyframe),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd)
    );

    // Decouple parsing from output expansion.
    lpsc_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_valid),
        .wr_cmd    (cmd),
        .rd_en     (head_pop),
        .rd_cmd    (head),
        .not_empty (head_valid),
        .full      (full)
    );

    // Expand commands into output bytes.
    lpsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .head_pop      (head_pop),
        .pop           (pop),
        .empty         (empty),
        .out_byte      (out_byte),
        .is_start_code (is_start_code),
        .run_last      (run_last)
    );

endmodule

>>> rtl/core/lpsc_checker.sv
// Port-level checks for the converter, attached to the top level by bind.
module lpsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       is_start_code,
    input logic       run_last
);

    // A waiting result holds until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(run_last)))
        else $error("waiting result changed before transfer");

    // Start code bytes are zero until the closing one, which ends the run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_start_code) |->
            ((out_byte == 8'h00 && !run_last) || (out_byte == 8'h01 && run_last)))
        else $error("malformed start code byte");

    // A copied payload byte is the only result of its input byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_start_code) |-> run_last)
        else $error("payload byte without run_last");

    // The bytes of a start code leave without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && is_start_code && !run_last) |=> (!empty && is_start_code))
        else $error("start code interrupted");

endmodule

bind length_prefixed_to_start_code lpsc_checker u_lpsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .is_start_code (is_start_code),
    .run_last      (run_last)
);

>>> test/tb_top.sv
// Self-checking testbench for the length-prefixed to start-code converter.
module tb_top;

    import lpsc_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 10;
    localparam int PHASE_SENDS = 3;

    // One byte of the Annex B stream as the converter should present it.
    typedef struct packed {
        logic [7:0] data;
        logic       is_sc;
        logic       run_end;
    } annexb_byte_t;

    // Tracks the parser state, predicts output bytes and checks the real ones.
    class annexb_scoreboard;
        annexb_byte_t expected_q[$];
        logic [2:0]   len_size;
        logic         keys_only;
        phase_t       phase;
        logic [1:0]   prefix_seen;
        logic [31:0]  unit_len;
        logic [31:0]  payload_left;
        int           errors;

        function new();
            len_size  = LEN_SIZE_RESET;
            keys_only = 1'b0;
            errors    = 0;
            clear_unit();
        endfunction

        function void clear_unit();
            phase        = PH_LEN;
            prefix_seen  = 2'd0;
            unit_len     = 32'd0;
            payload_left = 32'd0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] val);
            if (idx == REG_LENGTH_SIZE)
            begin
                len_size = val;
            end
            else if (idx == REG_KEYS_ONLY)
            begin
                keys_only = val[0];
            end
        endfunction

        function void emit(input logic [7:0] d, input logic sc, input logic e);
            annexb_byte_t item;
            item.data    = d;
            item.is_sc   = sc;
            item.run_end = e;
            expected_q.push_back(item);
        endfunction

        // Notes one accepted input byte; returns 1 only if the byte was used as prefix or payload.
        // Saturating a huge remaining count changes neither the "> 4" nor the "<= 1" test.
        function bit note_byte(input logic [7:0] b, input logic [24:0] rem, input logic key);
            bit          last_one;
            bit          used;
            int unsigned lsz;
            last_one = (rem <= 1);
            used     = 1'b0;
            lsz      = (len_size >= 1 && len_size <= 4) ? len_size : 1;
            if (keys_only && !key)
            begin
                if (last_one)
                begin
                    clear_unit();
                end
                return 1'b0;
            end
            case (phase)
                PH_LEN:
                begin
                    if (prefix_seen == 0 && rem <= 4)
                    begin
                        phase = PH_TRAIL;
                    end
                    else
                    begin
                        used = 1'b1;
                        if (lsz == 4 || lsz == 2)
                        begin
                            unit_len = {unit_len[23:0], b};
                        end
                        else if (prefix_seen == 0)
                        begin
                            unit_len = {24'd0, b};
                        end
                        if (prefix_seen + 1 >= lsz)
                        begin
                            emit(SC_ZERO_BYTE, 1'b1, 1'b0);
                            emit(SC_ZERO_BYTE, 1'b1, 1'b0);
                            emit(SC_ZERO_BYTE, 1'b1, 1'b0);
                            emit(SC_LAST_BYTE, 1'b1, 1'b1);
                            payload_left = unit_len;
                            unit_len     = 32'd0;
                            prefix_seen  = 2'd0;
                            if (payload_left != 0)
                            begin
                                phase = PH_PAY;
                            end
                            else
                            begin
                                phase = PH_LEN;
                            end
                        end
                        else
                        begin
                            prefix_seen = prefix_seen + 2'd1;
                        end
                    end
                end
                PH_PAY:
                begin
                    used = 1'b1;
                    emit(b, 1'b0, 1'b1);
                    payload_left = payload_left - 32'd1;
                    if (payload_left == 0)
                    begin
                        phase = PH_LEN;
                    end
                end
                default:
                begin
                end
            endcase
            if (last_one)
            begin
                clear_unit();
            end
            return used;
        endfunction

        function void check_byte(input logic [7:0] d, input logic sc, input logic e);
            annexb_byte_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output byte, expected none, got %h sc=%b end=%b",
                         $time, d, sc, e);
                return;
            end
            want = expected_q.pop_front();
            if (want.data !== d)
            begin
                errors++;
                $display("%0t: out_byte expected %h, got %h", $time, want.data, d);
            end
            if (want.is_sc !== sc)
            begin
                errors++;
                $display("%0t: is_start_code expected %b, got %b", $time, want.is_sc, sc);
            end
            if (want.run_end !== e)
            begin
                errors++;
                $display("%0t: run_last expected %b, got %b", $time, want.run_end, e);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    logic                   full;
    logic [7:0]             data_byte;
    logic [24:0]            bytes_remaining;
    logic                   is_keyframe;
    logic                   empty;
    logic                   pop;
    logic [7:0]             out_byte;
    logic                   is_start_code;
    logic                   run_last;

    annexb_scoreboard sb = new();
    bit  calm = 1'b0;
    bit  hold_long = 1'b0;

    length_prefixed_to_start_code dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .data_byte       (data_byte),
        .bytes_remaining (bytes_remaining),
        .is_keyframe     (is_keyframe),
        .empty           (empty),
        .pop             (pop),
        .out_byte        (out_byte),
        .is_start_code   (is_start_code),
        .run_last        (run_last)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Record every transfer on both sides at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                sb.check_byte(out_byte, is_start_code, run_last);
            end
            if (push && !full)
            begin
                void'(sb.note_byte(data_byte, bytes_remaining, is_keyframe));
            end
        end
    end

    // Receiver: random pop bursts, one long hold-off on request, steady pop when calm.
    initial
    begin : receiver
        pop = 1'b0;
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_long)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_long = 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (push && !full) || (pop && !empty))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offers one byte, with an occasional gap first, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic [24:0] rem, input logic key);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push            <= 1'b1;
        data_byte       <= b;
        bytes_remaining <= rem;
        is_keyframe     <= key;
        do
        begin
            @(posedge clk);
        end
        while (full);
    endtask

    // Stops offering and waits until every predicted byte has come out.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One well-formed sample of one to three units, sometimes cut short or with a tail.
    task automatic send_sample(input logic [2:0] lsz_cfg);
        logic [7:0]  bytes_q[$];
        logic [31:0] len_word;
        logic [24:0] rem;
        logic        key;
        logic        wide_rem;
        int unsigned prefix_n;
        int unsigned units;
        int unsigned body;
        int unsigned n;
        key      = ($urandom_range(0, 3) != 0);
        wide_rem = ($urandom_range(0, 3) == 0);
        prefix_n = (lsz_cfg >= 1 && lsz_cfg <= 4) ? lsz_cfg : 1;
        units    = $urandom_range(1, 3);
        for (int u = 0; u < units; u++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                len_word = $urandom;
            end
            else
            begin
                len_word = $urandom_range(0, 12);
            end
            for (int i = 0; i < prefix_n; i++)
            begin
                if (prefix_n == 4)
                begin
                    bytes_q.push_back(len_word[31 - 8 * i -: 8]);
                end
                else if (prefix_n == 2)
                begin
                    bytes_q.push_back(len_word[15 - 8 * i -: 8]);
                end
                else if (i == 0)
                begin
                    bytes_q.push_back(len_word[7:0]);
                end
                else
                begin
                    bytes_q.push_back(8'($urandom));
                end
            end
            if (prefix_n != 4 && prefix_n != 2)
            begin
                len_word = {24'd0, len_word[7:0]};
            end
            else if (prefix_n == 2)
            begin
                len_word = {16'd0, len_word[15:0]};
            end
            body = (len_word > 20) ? $urandom_range(0, 20) : len_word;
            if (u == units - 1 && $urandom_range(0, 4) == 0)
            begin
                body = $urandom_range(0, body);
            end
            repeat (body) bytes_q.push_back(8'($urandom));
            if (body < len_word)
            begin
                break;
            end
        end
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 4)) bytes_q.push_back(8'($urandom));
        end
        n = bytes_q.size();
        for (int i = 0; i < n; i++)
        begin
            rem = 25'(n - i);
            if (wide_rem && rem > 4)
            begin
                rem = 25'($urandom_range(5, 25'h1FFFFFF));
            end
            send_byte(bytes_q[i], rem, key);
        end
    endtask

    // A short run of bytes with arbitrary fields, often closed by a last byte.
    task automatic send_noise();
        logic [24:0] rem;
        int          n;
        n = $urandom_range(1, 5);
        repeat (n)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                rem = 25'($urandom_range(0, 25'h1FFFFFF));
            end
            else
            begin
                rem = 25'($urandom_range(0, 6));
            end
            send_byte(8'($urandom), rem, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1) == 0)
        begin
            send_byte(8'($urandom), 25'd1, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] sample_a[8] = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h80, 8'h5A, 8'hA5};
        logic [7:0] sample_b[9] = '{8'h00, 8'h00, 8'h00, 8'h00,
                                    8'h00, 8'h00, 8'h00, 8'h05, 8'h7E};
        logic [2:0] phase_len[PHASES] = '{3'd4, 3'd2, 3'd1, 3'd3, 3'd0,
                                          3'd5, 3'd2, 3'd6, 3'd7, 3'd4};
        logic       phase_key[PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                          1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_LENGTH_SIZE;
        cfg_data        = '0;
        push            = 1'b0;
        data_byte       = 8'h00;
        bytes_remaining = 25'd0;
        is_keyframe     = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a two-byte unit, then a unit start too close to the end.
        foreach (sample_a[i])
        begin
            send_byte(sample_a[i], 25'(8 - i), 1'b1);
        end
        // Zero-length unit, then a payload that runs past the sample end.
        foreach (sample_b[i])
        begin
            send_byte(sample_b[i], 25'(9 - i), 1'b1);
        end
        // Zero remaining counts as a last byte; the largest count starts a prefix.
        send_byte(8'h00, 25'd0, 1'b0);
        send_byte(8'hFF, 25'h1FFFFFF, 1'b1);
        send_byte(8'h00, 25'd0, 1'b1);
        drain();

        // Odd prefix size with keys-only: non-keyframe bytes leave the unit untouched.
        write_reg(REG_LENGTH_SIZE, 3'd7);
        write_reg(REG_KEYS_ONLY, 3'b001);
        send_byte(8'h03, 25'd6, 1'b1);
        send_byte(8'h42, 25'd5, 1'b0);
        send_byte(8'h11, 25'd4, 1'b1);
        send_byte(8'hEE, 25'd3, 1'b1);
        send_byte(8'h99, 25'd1, 1'b0);
        drain();

        // Random phases, each under its own register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_LENGTH_SIZE, phase_len[p]);
            write_reg(REG_KEYS_ONLY, {2'($urandom_range(0, 3)), phase_key[p]});
            if (p == 1)
            begin
                hold_long = 1'b1;
            end
            if (p == PHASES - 1)
            begin
                calm = 1'b1;
            end
            repeat (PHASE_SENDS)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    send_noise();
                end
                else
                begin
                    send_sample(phase_len[p]);
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
